>>> src/bmra_pkg.sv
package bmra_pkg;

  localparam int unsigned MapBytes = 512;
  localparam int unsigned AddrW    = $clog2(MapBytes);
  localparam int unsigned LimW     = AddrW + 1;
  localparam int unsigned BitIdxW  = 12;
  localparam int unsigned RunLenW  = 13;
  localparam int unsigned CfgW     = 10;

  typedef enum logic [1:0] {
    CMD_TEST  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ALLOC = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLEAR  = 7'b0000010,
    ST_TEST   = 7'b0000100,
    ST_WRITE  = 7'b0001000,
    ST_SEARCH = 7'b0010000,
    ST_RESP   = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_e;

endpackage

>>> src/bitmap_run_allocator_unit.sv
// First-fit run allocator over a 512-byte allocation bitmap (1 = used, 0 = free) held in a
// single synchronous RAM with a registered read port. Each request gives exactly one response.
// A test reads the byte and then picks out the bit, a write is a read-modify-write of one
// byte, and an allocate streams the bitmap one byte per cycle through the RAM read port,
// reading at most min(bytes_in_use, 512) bytes and ending early at the first fitting run.
// Clearing the whole bitmap writes all 512 bytes, one byte per cycle.
// After reset the block runs the same clearing pass before it accepts its first
// request; configuration writes are accepted at any time. The response sits in an output
// register, so a new request can be accepted while the previous response waits to be taken.
module bitmap_run_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [bmra_pkg::CfgW-1:0] cfg_data_i,   // bytes_in_use

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,    // bit_index[11:0], bit_value[12], run_length[25:13]
  input  logic [1:0]  s_axis_tuser_i,    // cmd[1:0]

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o     // bit_is_set[0], run_start[12:1], status[13]
);
  import bmra_pkg::*;

  // The bitmap itself. Bit k of byte b is allocation unit b*8+k.
  logic [7:0] mem_q [MapBytes];
  logic [7:0] rdata_q;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Configuration register, reset to the full store.
  logic [CfgW-1:0] bytes_in_use_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_in_use_q <= CfgW'(MapBytes);
    end else if (cfg_valid_i) begin
      bytes_in_use_q <= cfg_data_i;
    end
  end

  // The search limit in bytes, clamped to the store size.
  logic [LimW-1:0] lim;
  assign lim = (bytes_in_use_q > CfgW'(MapBytes)) ? LimW'(MapBytes) : LimW'(bytes_in_use_q);

  // Unpacked request fields.
  cmd_e               in_cmd;
  logic [BitIdxW-1:0] in_idx;
  logic               in_val;
  logic [RunLenW-1:0] in_len;

  assign in_cmd = cmd_e'(s_axis_tuser_i);
  assign in_idx = s_axis_tdata_i[11:0];
  assign in_val = s_axis_tdata_i[12];
  assign in_len = s_axis_tdata_i[25:13];

  state_e             state_q, state_d;
  logic [BitIdxW-1:0] idx_q, idx_d;
  logic               val_q, val_d;
  logic [RunLenW-1:0] len_q, len_d;
  logic [LimW-1:0]    lim_q, lim_d;
  logic               clr_cmd_q, clr_cmd_d;
  logic [AddrW-1:0]   clr_q, clr_d;

  // Search pointers: rd_ptr is the next byte to read; pb is the byte whose data
  // arrives this cycle when pv is set.
  logic [LimW-1:0]    rd_ptr_q, rd_ptr_d;
  logic               pv_q, pv_d;
  logic [AddrW-1:0]   pb_q, pb_d;
  logic [RunLenW-1:0] cnt_q, cnt_d;
  logic [BitIdxW-1:0] st_q, st_d;

  // Pending response and output register.
  logic               res_bit_q, res_bit_d;
  logic [BitIdxW-1:0] res_start_q, res_start_d;
  logic               res_status_q, res_status_d;
  logic               m_valid_q, m_valid_d;
  logic [15:0]        m_data_q, m_data_d;

  logic accept;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // One byte of the search: count free bits onward, restarting after a used bit,
  // and flag the first position where the count reaches the wanted length.
  logic [RunLenW-1:0] scan_cnt;
  logic [BitIdxW-1:0] scan_st;
  logic               scan_hit;
  logic [BitIdxW-1:0] scan_hit_st;

  always_comb begin
    scan_cnt    = cnt_q;
    scan_st     = st_q;
    scan_hit    = 1'b0;
    scan_hit_st = '0;
    for (int k = 0; k < 8; k++) begin
      if (!scan_hit) begin
        if (rdata_q[k]) begin
          scan_cnt = '0;
        end else begin
          if (scan_cnt == '0) begin
            scan_st = {pb_q, 3'(k)};
          end
          scan_cnt = scan_cnt + RunLenW'(1);
          if (scan_cnt == len_q) begin
            scan_hit    = 1'b1;
            scan_hit_st = scan_st;
          end
        end
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    val_d        = val_q;
    len_d        = len_q;
    lim_d        = lim_q;
    clr_cmd_d    = clr_cmd_q;
    clr_d        = clr_q;
    rd_ptr_d     = rd_ptr_q;
    pv_d         = 1'b0;
    pb_d         = pb_q;
    cnt_d        = cnt_q;
    st_d         = st_q;
    res_bit_d    = res_bit_q;
    res_start_d  = res_start_q;
    res_status_d = res_status_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    rd_en        = 1'b0;
    rd_addr      = in_idx[BitIdxW-1:3];
    wr_en        = 1'b0;
    wr_addr      = idx_q[BitIdxW-1:3];
    wr_data      = rdata_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d        = in_idx;
          val_d        = in_val;
          len_d        = in_len;
          res_bit_d    = 1'b0;
          res_start_d  = '0;
          res_status_d = 1'b0;
          unique case (in_cmd)
            CMD_TEST: begin
              rd_en   = 1'b1;
              state_d = ST_TEST;
            end
            CMD_WRITE: begin
              rd_en   = 1'b1;
              state_d = ST_WRITE;
            end
            CMD_ALLOC: begin
              lim_d    = lim;
              rd_ptr_d = '0;
              cnt_d    = '0;
              st_d     = '0;
              if (in_len == '0 || lim == '0) begin
                res_status_d = 1'b1;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_SEARCH;
              end
            end
            CMD_CLEAR: begin
              clr_d     = '0;
              clr_cmd_d = 1'b1;
              state_d   = ST_CLEAR;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MapBytes - 1)) begin
          state_d = clr_cmd_q ? ST_RESP : ST_IDLE;
        end
      end

      ST_TEST: begin
        res_bit_d = rdata_q[idx_q[2:0]];
        state_d   = ST_RESP;
      end

      ST_WRITE: begin
        wr_en = 1'b1;
        if (val_q) begin
          wr_data = rdata_q | (8'd1 << idx_q[2:0]);
        end else begin
          wr_data = rdata_q & ~(8'd1 << idx_q[2:0]);
        end
        state_d = ST_RESP;
      end

      ST_SEARCH: begin
        if (rd_ptr_q != lim_q) begin
          rd_en    = 1'b1;
          rd_addr  = rd_ptr_q[AddrW-1:0];
          rd_ptr_d = rd_ptr_q + LimW'(1);
          pv_d     = 1'b1;
          pb_d     = rd_ptr_q[AddrW-1:0];
        end
        if (pv_q) begin
          cnt_d = scan_cnt;
          st_d  = scan_st;
        end
        if (pv_q && scan_hit) begin
          pv_d         = 1'b0;
          res_start_d  = scan_hit_st;
          res_status_d = 1'b0;
          state_d      = ST_RESP;
        end else if (rd_ptr_q == lim_q) begin
          res_status_d = 1'b1;
          state_d      = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00, res_status_q, res_start_q, res_bit_q};
          clr_cmd_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      clr_cmd_q <= 1'b0;
      pv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_cmd_q <= clr_cmd_d;
      pv_q      <= pv_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    val_q        <= val_d;
    len_q        <= len_d;
    lim_q        <= lim_d;
    rd_ptr_q     <= rd_ptr_d;
    pb_q         <= pb_d;
    cnt_q        <= cnt_d;
    st_q         <= st_d;
    res_bit_q    <= res_bit_d;
    res_start_q  <= res_start_d;
    res_status_q <= res_status_d;
    m_data_q     <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
